>>> sv/fisher2pl_pkg.sv
// ----------------------------------------------------------------------------
// fisher2pl_pkg
// Shared types, register indexes and the elaboration-time builder for the
// logistic variance table p(1-p).
// ----------------------------------------------------------------------------
package fisher2pl_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOPE    = 2'd1;

   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int Q_SHIFT = 24;       // Q.56 products down to Q.32
   localparam int ENT_W   = 16;       // table entry, Q0.16

   typedef enum logic [1:0] {
      ACC_AA,
      ACC_AB,
      ACC_BB
   } acc_sel_type;

   typedef struct packed {
      logic        add;
      acc_sel_type sel;
      logic        neg;
      logic        clear;
   } acc_ctrl_type;

   // restoring long division, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int k = 63; k >= 0; k--) begin
         rem = {rem[62:0], num[k]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[k] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-8u) in Q1.31 for u in Q0.31: Taylor series for exp(-u), then squared three times
   function automatic logic [63:0] exp_neg_q31(input logic [63:0] u);
      longint      acc;
      logic [63:0] term;
      logic [63:0] e;
      acc  = 64'sd2147483648;
      term = 64'd2147483648;
      for (int n = 1; n <= 16; n++) begin
         term = udiv64((term * u) >> 31, 64'(n));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > 64'sd2147483648) begin
         acc = 64'sd2147483648;
      end
      e = 64'(acc);
      for (int k = 0; k < 3; k++) begin
         e = (e * e + 64'd1073741824) >> 31;
      end
      return e;
   endfunction

   // entry at the midpoint of cell i of a table of depth cells over z in [-8,8)
   function automatic logic [ENT_W-1:0] var_entry(input int i, input int depth);
      longint      off;
      logic [63:0] mag;
      logic [63:0] u;
      logic [63:0] e;
      logic [63:0] q;
      logic [63:0] r;
      off = 2 * longint'(i) + 1 - longint'(depth);
      mag = 64'((off < 0) ? -off : off);
      u   = udiv64(mag << 31, 64'(depth));
      e   = exp_neg_q31(u);
      q   = udiv64(e << 31, 64'd2147483648 + e);
      r   = udiv64(q << 31, 64'd2147483648 + e);
      return ENT_W'((r + 64'd16384) >> 15);
   endfunction

endpackage

>>> sv/fisher2pl_var_rom.sv
// ----------------------------------------------------------------------------
// fisher2pl_var_rom
// Constant table of the logistic variance p(1-p) over z in [-8,8), registered
// read.
// ----------------------------------------------------------------------------
module fisher2pl_var_rom import fisher2pl_pkg::*; #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic [$clog2(TABLE_DEPTH)-1:0] idx,
   output logic [ENT_W-1:0]               data_ff
);

   logic [ENT_W-1:0] rom [TABLE_DEPTH];

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
      localparam logic [ENT_W-1:0] Entry = var_entry(g, TABLE_DEPTH);
      assign rom[g] = Entry;
   end

   always_ff @(posedge clock) begin
      data_ff <= rom[idx];
   end

endmodule

>>> sv/fisher2pl_mul.sv
// ----------------------------------------------------------------------------
// fisher2pl_mul
// Shared unsigned 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module fisher2pl_mul import fisher2pl_pkg::*; (
   input  logic              clock,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0] prod_ff
);

   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> sv/fisher2pl_acc.sv
// ----------------------------------------------------------------------------
// fisher2pl_acc
// Three saturating accumulators behind one shared round-and-add unit.
// Products arrive as Q.56 magnitudes and are rounded half away from zero.
// ----------------------------------------------------------------------------
module fisher2pl_acc import fisher2pl_pkg::*; #(
   parameter int ACC_WIDTH = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  acc_ctrl_type                ctrl,
   input  logic [PROD_W-1:0]           prod,
   output logic signed [ACC_WIDTH-1:0] sum_aa_ff,
   output logic signed [ACC_WIDTH-1:0] sum_ab_ff,
   output logic signed [ACC_WIDTH-1:0] sum_bb_ff
);

   localparam int SumW = ((ACC_WIDTH > 41) ? ACC_WIDTH : 41) + 1;
   localparam logic signed [SumW-1:0] AccMax =
      {{(SumW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [SumW-1:0] AccMin = ~AccMax;

   logic [PROD_W-1:0]           rounded;
   logic signed [SumW-1:0]      term_mag;
   logic signed [SumW-1:0]      term;
   logic signed [SumW-1:0]      base;
   logic signed [SumW-1:0]      total;
   logic signed [ACC_WIDTH-1:0] sum_sel;
   logic signed [ACC_WIDTH-1:0] sat;
   logic signed [ACC_WIDTH-1:0] sum_aa_in;
   logic signed [ACC_WIDTH-1:0] sum_ab_in;
   logic signed [ACC_WIDTH-1:0] sum_bb_in;

   always_comb begin
      rounded  = (prod + (PROD_W'(1) << (Q_SHIFT - 1))) >> Q_SHIFT;
      term_mag = SumW'(rounded);
      term     = ctrl.neg ? -term_mag : term_mag;
      case (ctrl.sel)
         ACC_AA:  sum_sel = sum_aa_ff;
         ACC_AB:  sum_sel = sum_ab_ff;
         ACC_BB:  sum_sel = sum_bb_ff;
         default: sum_sel = sum_bb_ff;
      endcase
      base  = SumW'(sum_sel);
      total = base + term;
      if (total > AccMax) begin
         sat = ACC_WIDTH'(AccMax);
      end else if (total < AccMin) begin
         sat = ACC_WIDTH'(AccMin);
      end else begin
         sat = ACC_WIDTH'(total);
      end

      sum_aa_in = sum_aa_ff;
      sum_ab_in = sum_ab_ff;
      sum_bb_in = sum_bb_ff;
      if (ctrl.clear) begin
         sum_aa_in = '0;
         sum_ab_in = '0;
         sum_bb_in = '0;
      end else if (ctrl.add) begin
         case (ctrl.sel)
            ACC_AA:  sum_aa_in = sat;
            ACC_AB:  sum_ab_in = sat;
            ACC_BB:  sum_bb_in = sat;
            default: sum_bb_in = sum_bb_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_aa_ff <= '0;
         sum_ab_ff <= '0;
         sum_bb_ff <= '0;
      end else begin
         sum_aa_ff <= sum_aa_in;
         sum_ab_ff <= sum_ab_in;
         sum_bb_ff <= sum_bb_in;
      end
   end

endmodule

>>> sv/fisher_info_logistic_2pl.sv
// ----------------------------------------------------------------------------
// fisher_info_logistic_2pl
// Accumulates the 2x2 Fisher information of the 2PL logistic model over a
// set of weighted design points.
// ----------------------------------------------------------------------------
// A design point keeps the block from accepting the next point until its
// work is done: one shared 32x32 multiplier forms |b*d|, d^2,
// b^2, weight*p(1-p) and the three weighted products in turn, one per cycle,
// and a single round-and-saturate adder folds them into the sums. req_stall is
// high for the whole of that sequence. On a point with last set the matrix
// moves to the output register and the sums clear; if the previous matrix has
// not been taken yet, the block waits for that before finishing. Config
// registers (0: location, 1: slope, both Q4.12) are always writable but should
// be changed only while the block is idle.
module fisher_info_logistic_2pl import fisher2pl_pkg::*; #(
   parameter int TABLE_DEPTH = 256,
   parameter int ACC_WIDTH   = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [15:0]     req_x_point,
   input  logic [15:0]            req_weight,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [46:0]            rsp_info_aa,
   output logic signed [47:0]     rsp_info_ab,
   output logic [46:0]            rsp_info_bb,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data
);

   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam int TdW  = $clog2(TABLE_DEPTH + 1);
   localparam int ZsW  = 28 + TdW;
   localparam int ExtW = (ACC_WIDTH > 48) ? ACC_WIDTH : 48;
   localparam logic [ZsW-1:0] DepthK = ZsW'(TABLE_DEPTH);
   localparam logic signed [ExtW-1:0] Max47 = {{(ExtW-47){1'b0}}, {47{1'b1}}};
   localparam logic signed [ExtW-1:0] Min48 = ~Max47;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BD,
      S_DD,
      S_B2,
      S_V,
      S_AA,
      S_AB,
      S_BB,
      S_FIN,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] loc_ff, loc_in;
   logic signed [15:0] slope_ff, slope_in;
   logic [15:0]        weight_ff, weight_in;
   logic               last_ff, last_in;
   logic [15:0]        dmag_ff, dmag_in;
   logic               dneg_ff, dneg_in;
   logic [30:0]        bdm_ff, bdm_in;
   logic [31:0]        dd_ff, dd_in;
   logic [30:0]        b2_ff, b2_in;
   logic [29:0]        v_ff, v_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [46:0]        info_aa_ff, info_aa_in;
   logic signed [47:0] info_ab_ff, info_ab_in;
   logic [46:0]        info_bb_ff, info_bb_in;

   logic                        req_take;
   logic                        rsp_take;
   logic                        sneg;
   logic [15:0]                 smag;
   logic signed [16:0]          d_full;
   logic                        zneg;
   logic [27:0]                 zoff;
   logic [ZsW-1:0]              zscaled;
   logic [MUL_W-1:0]            mul_a;
   logic [MUL_W-1:0]            mul_b;
   logic [PROD_W-1:0]           prod;
   logic [ENT_W-1:0]            ent;
   acc_ctrl_type                acc_ctrl;
   logic signed [ACC_WIDTH-1:0] sum_aa;
   logic signed [ACC_WIDTH-1:0] sum_ab;
   logic signed [ACC_WIDTH-1:0] sum_bb;
   logic signed [ExtW-1:0]      ext_aa;
   logic signed [ExtW-1:0]      ext_ab;
   logic signed [ExtW-1:0]      ext_bb;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign rsp_take    = rsp_valid_ff && !rsp_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_info_aa = info_aa_ff;
   assign rsp_info_ab = info_ab_ff;
   assign rsp_info_bb = info_bb_ff;

   assign sneg   = slope_ff[15];
   assign smag   = sneg ? 16'(-slope_ff) : 16'(slope_ff);
   assign d_full = 17'(req_x_point) - 17'(loc_ff);
   assign zneg   = sneg ^ dneg_ff;

   fisher2pl_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   fisher2pl_var_rom #(.TABLE_DEPTH(TABLE_DEPTH)) u_rom (
      .clock   (clock),
      .idx     (idx_ff),
      .data_ff (ent)
   );

   fisher2pl_acc #(.ACC_WIDTH(ACC_WIDTH)) u_acc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (acc_ctrl),
      .prod      (prod),
      .sum_aa_ff (sum_aa),
      .sum_ab_ff (sum_ab),
      .sum_bb_ff (sum_bb)
   );

   // multiplier operand select
   always_comb begin
      case (state_ff)
         S_BD: begin
            mul_a = MUL_W'(smag);
            mul_b = MUL_W'(dmag_ff);
         end
         S_DD: begin
            mul_a = MUL_W'(dmag_ff);
            mul_b = MUL_W'(dmag_ff);
         end
         S_B2: begin
            mul_a = MUL_W'(smag);
            mul_b = MUL_W'(smag);
         end
         S_V: begin
            mul_a = MUL_W'(weight_ff);
            mul_b = MUL_W'(ent);
         end
         S_AA: begin
            mul_a = MUL_W'(b2_ff);
            mul_b = MUL_W'(prod[29:0]);
         end
         S_AB: begin
            mul_a = MUL_W'(bdm_ff);
            mul_b = MUL_W'(v_ff);
         end
         S_BB: begin
            mul_a = MUL_W'(dd_ff);
            mul_b = MUL_W'(v_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // clamp z = b*d to [-8,8) and map to a table cell
   always_comb begin
      if (prod[30:0] >= 31'h0800_0000) begin
         zoff = zneg ? 28'd0 : 28'hFFF_FFFF;
      end else if (zneg) begin
         zoff = 28'h800_0000 - prod[27:0];
      end else begin
         zoff = 28'h800_0000 + prod[27:0];
      end
      zscaled = ZsW'(zoff) * DepthK;
   end

   assign ext_aa = ExtW'(sum_aa);
   assign ext_ab = ExtW'(sum_ab);
   assign ext_bb = ExtW'(sum_bb);

   always_comb begin
      state_in     = state_ff;
      loc_in       = loc_ff;
      slope_in     = slope_ff;
      weight_in    = weight_ff;
      last_in      = last_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      bdm_in       = bdm_ff;
      dd_in        = dd_ff;
      b2_in        = b2_ff;
      v_in         = v_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      info_aa_in   = info_aa_ff;
      info_ab_in   = info_ab_ff;
      info_bb_in   = info_bb_ff;
      acc_ctrl     = '{add: 1'b0, sel: ACC_AA, neg: 1'b0, clear: 1'b0};

      if (csr_valid) begin
         case (csr_index)
            CSR_LOCATION: loc_in   = csr_data;
            CSR_SLOPE:    slope_in = csr_data;
            default:      loc_in   = loc_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               weight_in = req_weight;
               last_in   = req_last;
               dneg_in   = d_full[16];
               dmag_in   = 16'(d_full[16] ? -d_full : d_full);
               state_in  = S_BD;
            end
         end
         S_BD: state_in = S_DD;
         S_DD: begin
            bdm_in   = prod[30:0];
            idx_in   = IdxW'(zscaled >> 28);
            state_in = S_B2;
         end
         S_B2: begin
            dd_in    = prod[31:0];
            state_in = S_V;
         end
         S_V: begin
            b2_in    = prod[30:0];
            state_in = S_AA;
         end
         S_AA: begin
            v_in     = prod[29:0];
            state_in = S_AB;
         end
         S_AB: begin
            acc_ctrl = '{add: 1'b1, sel: ACC_AA, neg: 1'b0, clear: 1'b0};
            state_in = S_BB;
         end
         S_BB: begin
            // off-diagonal term is -b*d*v: negative when b*d is positive
            acc_ctrl = '{add: 1'b1, sel: ACC_AB, neg: !zneg, clear: 1'b0};
            state_in = S_FIN;
         end
         S_FIN: begin
            acc_ctrl = '{add: 1'b1, sel: ACC_BB, neg: 1'b0, clear: 1'b0};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (ext_aa < 0) begin
                  info_aa_in = '0;
               end else if (ext_aa > Max47) begin
                  info_aa_in = 47'(Max47);
               end else begin
                  info_aa_in = 47'(ext_aa);
               end
               if (ext_ab < Min48) begin
                  info_ab_in = 48'(Min48);
               end else if (ext_ab > Max47) begin
                  info_ab_in = 48'(Max47);
               end else begin
                  info_ab_in = 48'(ext_ab);
               end
               if (ext_bb < 0) begin
                  info_bb_in = '0;
               end else if (ext_bb > Max47) begin
                  info_bb_in = 47'(Max47);
               end else begin
                  info_bb_in = 47'(ext_bb);
               end
               acc_ctrl = '{add: 1'b0, sel: ACC_AA, neg: 1'b0, clear: 1'b1};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loc_ff       <= 16'sd0;
         slope_ff     <= 16'sd4096;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loc_ff       <= loc_in;
         slope_ff     <= slope_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      weight_ff  <= weight_in;
      last_ff    <= last_in;
      dmag_ff    <= dmag_in;
      dneg_ff    <= dneg_in;
      bdm_ff     <= bdm_in;
      dd_ff      <= dd_in;
      b2_ff      <= b2_in;
      v_ff       <= v_in;
      idx_ff     <= idx_in;
      info_aa_ff <= info_aa_in;
      info_ab_ff <= info_ab_in;
      info_bb_ff <= info_bb_in;
   end

endmodule

>>> sv/fisher2pl_chk.sv
// ----------------------------------------------------------------------------
// fisher2pl_chk
// Port-level checks for the Fisher information accumulator.
// ----------------------------------------------------------------------------
module fisher2pl_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [46:0]        rsp_info_aa,
   input logic signed [47:0] rsp_info_ab,
   input logic [46:0]        rsp_info_bb
);

   // the block is still busy late in the multiply sequence of a taken beat
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##7 req_stall)
      else $error("input taken again too early");

   // a matrix only shows up while a point is being worked on
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result with no point in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_info_aa) && $stable(rsp_info_ab)
                                 && $stable(rsp_info_bb))
      else $error("stalled result changed");

endmodule

bind fisher_info_logistic_2pl fisher2pl_chk u_fisher2pl_chk (.*);

>>> sim/fisher_info_checker.sv
// ----------------------------------------------------------------------------
// fisher_info_checker
// Passive monitor for the 2PL Fisher information block. Mirrors the register
// writes, predicts the three matrix entries for every set of design points and
// compares each result beat against the oldest predicted matrix.
// ----------------------------------------------------------------------------
module fisher_info_checker import fisher2pl_pkg::*; #(
   parameter int LUT_DEPTH = 256,
   parameter int ACC_BITS  = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic signed [15:0]     req_x_point,
   input  logic [15:0]            req_weight,
   input  logic                   req_last,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [46:0]            rsp_info_aa,
   input  logic signed [47:0]     rsp_info_ab,
   input  logic [46:0]            rsp_info_bb,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data,
   output int                     mismatches,
   output int                     outstanding,
   output int                     points_seen,
   output int                     matrices_seen,
   output int                     saturated_seen
);

   typedef struct packed {
      logic [46:0]        aa;
      logic signed [47:0] ab;
      logic [46:0]        bb;
   } info_matrix_type;

   localparam logic [63:0] ONE_Q31 = 64'h8000_0000;
   localparam longint Z_LIMIT = 64'sd134217728;          // 8.0 in Q.24
   localparam longint MAX47   = 64'sd140737488355327;
   localparam longint ACC_HI  = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;
   localparam longint ACC_LO  = -ACC_HI - 64'sd1;

   logic [31:0]     var_lut [LUT_DEPTH];
   longint          location_q;
   longint          slope_q;
   longint          sum_aa;
   longint          sum_ab;
   longint          sum_bb;
   info_matrix_type matrix_q [$];

   // exp(-8u) in Q1.31: truncated Taylor series of exp(-u), then squared 3 times
   function automatic logic [63:0] decay_q31(input logic [63:0] u);
      longint      acc;
      logic [63:0] term;
      logic [63:0] e;
      acc  = longint'(ONE_Q31);
      term = ONE_Q31;
      for (int n = 1; n <= 16; n++) begin
         term = ((term * u) >> 31) / 64'(n);
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q31)) acc = longint'(ONE_Q31);
      e = $unsigned(acc);
      for (int k = 0; k < 3; k++) e = (e * e + (ONE_Q31 >> 1)) >> 31;
      return e;
   endfunction

   // p(1-p) at the midpoint of cell i, Q0.16
   function automatic logic [31:0] variance_at(input int i);
      longint      off;
      logic [63:0] mag;
      logic [63:0] u;
      logic [63:0] e;
      logic [63:0] q;
      logic [63:0] r;
      off = 2 * longint'(i) + 1 - longint'(LUT_DEPTH);
      mag = $unsigned((off < 0) ? -off : off);
      u   = (mag << 31) / 64'(LUT_DEPTH);
      e   = decay_q31(u);
      q   = (e << 31) / (ONE_Q31 + e);
      r   = (q << 31) / (ONE_Q31 + e);
      return 32'((r + 64'd16384) >> 15);
   endfunction

   // Q.56 magnitude to Q.32, halves away from zero
   function automatic longint round_q56(input bit neg, input logic [63:0] mag);
      longint m;
      m = longint'((mag + 64'h80_0000) >> 24);
      return neg ? -m : m;
   endfunction

   function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint sat_acc(input longint s, input longint t);
      if (t > 0 && s > ACC_HI - t) return ACC_HI;
      if (t < 0 && s < ACC_LO - t) return ACC_LO;
      return clamp_to(s + t, ACC_LO, ACC_HI);
   endfunction

   initial begin
      for (int i = 0; i < LUT_DEPTH; i++) var_lut[i] = variance_at(i);
   end

   task automatic fold_point(input logic signed [15:0] xp, input logic [15:0] w,
                             input logic lst);
      longint          d;
      longint          z;
      longint          bd;
      logic [63:0]     idx;
      logic [63:0]     v;
      logic [63:0]     b2;
      logic [63:0]     dd;
      logic [63:0]     bdm;
      info_matrix_type m;
      d = longint'(xp) - location_q;
      z = slope_q * d;
      if (z < -Z_LIMIT) z = -Z_LIMIT;
      if (z > Z_LIMIT - 1) z = Z_LIMIT - 1;
      idx = $unsigned((z + Z_LIMIT) * LUT_DEPTH) >> 28;
      if (idx >= 64'(LUT_DEPTH)) idx = 64'(LUT_DEPTH - 1);
      v   = 64'(w) * 64'(var_lut[idx]);
      b2  = $unsigned(slope_q * slope_q);
      dd  = $unsigned(d * d);
      bd  = slope_q * d;
      bdm = $unsigned((bd < 0) ? -bd : bd);
      sum_aa = sat_acc(sum_aa, round_q56(1'b0, b2 * v));
      sum_ab = sat_acc(sum_ab, round_q56(bd > 0, bdm * v));
      sum_bb = sat_acc(sum_bb, round_q56(1'b0, dd * v));
      points_seen++;
      if (lst) begin
         m.aa = 47'(clamp_to(sum_aa, 0, MAX47));
         m.ab = 48'(clamp_to(sum_ab, -MAX47 - 1, MAX47));
         m.bb = 47'(clamp_to(sum_bb, 0, MAX47));
         matrix_q.push_back(m);
         sum_aa = 0;
         sum_ab = 0;
         sum_bb = 0;
      end
   endtask

   task automatic check_matrix();
      info_matrix_type want;
      if (matrix_q.size() == 0) begin
         $error("unexpected matrix beat: info_aa %0d info_ab %0d info_bb %0d",
                rsp_info_aa, rsp_info_ab, rsp_info_bb);
         mismatches++;
      end else begin
         want = matrix_q.pop_front();
         matrices_seen++;
         if (want.bb == 47'(MAX47)) saturated_seen++;
         if (rsp_info_aa !== want.aa) begin
            $error("info_aa: expected %0d, actual %0d", want.aa, rsp_info_aa);
            mismatches++;
         end
         if (rsp_info_ab !== want.ab) begin
            $error("info_ab: expected %0d, actual %0d", $signed(want.ab), rsp_info_ab);
            mismatches++;
         end
         if (rsp_info_bb !== want.bb) begin
            $error("info_bb: expected %0d, actual %0d", want.bb, rsp_info_bb);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         location_q     = 0;
         slope_q        = 4096;
         sum_aa         = 0;
         sum_ab         = 0;
         sum_bb         = 0;
         matrix_q.delete();
         mismatches     = 0;
         points_seen    = 0;
         matrices_seen  = 0;
         saturated_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOCATION: location_q = longint'($signed(csr_data));
               CSR_SLOPE:    slope_q    = longint'($signed(csr_data));
               default: ;
            endcase
         end
         // drain before fill: a beat leaving this edge belongs to an older set
         if (rsp_valid && !rsp_stall) check_matrix();
         if (req_valid && !req_stall) fold_point(req_x_point, req_weight, req_last);
      end
      outstanding = matrix_q.size();
   end

endmodule

>>> sim/fisher_info_logistic_2pl_test.sv
// ----------------------------------------------------------------------------
// fisher_info_logistic_2pl_test
// Stimulus and verdict for the 2PL Fisher information block: directed corner
// points, random design sets under shifting stall patterns, a long output
// hold-off and a set long enough to saturate the d^2 sum.
// ----------------------------------------------------------------------------
module fisher_info_logistic_2pl_test import fisher2pl_pkg::*;;

   localparam int TABLE_DEPTH  = 256;
   localparam int ACC_WIDTH    = 48;
   localparam int SETTLE_TICKS = 16;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 5000;
   localparam int SAT_POINTS   = 530;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic signed [15:0]     req_x_point;
   logic [15:0]            req_weight;
   logic                   req_last;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [46:0]            rsp_info_aa;
   logic signed [47:0]     rsp_info_ab;
   logic [46:0]            rsp_info_bb;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [15:0]            csr_data;

   int mismatches;
   int outstanding;
   int points_seen;
   int matrices_seen;
   int saturated_seen;

   int send_idle;
   int recv_idle;
   bit hold_req;
   int cur_location;
   int idle_cycles;

   fisher_info_logistic_2pl #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .ACC_WIDTH  (ACC_WIDTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_x_point(req_x_point),
      .req_weight (req_weight),
      .req_last   (req_last),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_info_aa(rsp_info_aa),
      .rsp_info_ab(rsp_info_ab),
      .rsp_info_bb(rsp_info_bb),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   fisher_info_checker #(
      .LUT_DEPTH(TABLE_DEPTH),
      .ACC_BITS (ACC_WIDTH)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_x_point   (req_x_point),
      .req_weight    (req_weight),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_info_aa   (rsp_info_aa),
      .rsp_info_ab   (rsp_info_ab),
      .rsp_info_bb   (rsp_info_bb),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .points_seen   (points_seen),
      .matrices_seen (matrices_seen),
      .saturated_seen(saturated_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: random stall, plus one long hold-off on request
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle);
         end
      end
   end

   // ends the run if no beat moves on any channel for too long
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_point(input int x, input int w, input bit lst);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_x_point <= 16'(x);
      req_weight  <= 16'(w);
      req_last    <= lst;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 16'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      if (idx == CSR_LOCATION) cur_location = int'($signed(16'(value)));
   endtask

   // all results in, then a settling pause so the datapath goes quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   function automatic int pick_setting();
      case ($urandom_range(6))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return 1;
         5: return 4096;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   function automatic int pick_x();
      case ($urandom_range(9))
         0: return -32768;
         1: return 32767;
         2, 3, 4: return cur_location + int'($urandom_range(1024)) - 512;
         default: return int'($urandom_range(65535));
      endcase
   endfunction

   function automatic int pick_weight();
      case ($urandom_range(7))
         0: return 0;
         1: return 65535;
         default: return int'($urandom_range(65535));
      endcase
   endfunction

   task automatic reconfigure();
      settle();
      case ($urandom_range(3))
         0: write_csr(CSR_LOCATION, pick_setting());
         1: write_csr(CSR_SLOPE, pick_setting());
         2: begin
            write_csr(CSR_LOCATION, pick_setting());
            write_csr(CSR_SLOPE, pick_setting());
         end
         default: begin
            write_csr($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom_range(65535));
            write_csr(CSR_SLOPE, pick_setting());
         end
      endcase
   endtask

   task automatic run_sets(input int budget);
      int sent;
      int size;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(3) == 0) reconfigure();
         size = ($urandom_range(7) == 0) ? $urandom_range(16, 11) : $urandom_range(10, 1);
         for (int k = 0; k < size; k++) send_point(pick_x(), pick_weight(), k == size - 1);
         sent += size;
      end
   endtask

   task automatic directed_points();
      // reset settings: location 0, slope 1.0; peak variance and both z clamps
      send_point(0, 65535, 1'b1);
      send_point(32767, 65535, 1'b0);
      send_point(-32768, 65535, 1'b1);
      send_point(4096, 0, 1'b1);
      send_point(-4096, 1, 1'b0);
      send_point(2048, 32768, 1'b0);
      send_point(-1, 65535, 1'b1);
      // widest d with steepest negative slope
      settle();
      write_csr(CSR_LOCATION, 32767);
      write_csr(CSR_SLOPE, -32768);
      send_point(-32768, 65535, 1'b1);
      send_point(32767, 65535, 1'b0);
      send_point(32760, 40000, 1'b1);
      settle();
      write_csr(CSR_LOCATION, -32768);
      write_csr(CSR_SLOPE, 32767);
      send_point(32767, 65535, 1'b0);
      send_point(-32768, 65535, 1'b1);
      send_point(-32767, 65535, 1'b1);
      // zero slope: only the d^2 sum moves
      settle();
      write_csr(CSR_LOCATION, 0);
      write_csr(CSR_SLOPE, 0);
      send_point(32767, 65535, 1'b0);
      send_point(-32768, 12345, 1'b1);
      // unmapped indexes must leave the settings alone
      settle();
      write_csr(CSR_SPARE_LO, 65535);
      write_csr(CSR_SPARE_HI, 21845);
      write_csr(CSR_SLOPE, 4096);
      send_point(0, 65535, 1'b1);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_x_point  = '0;
      req_weight   = '0;
      req_last     = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_LOCATION;
      csr_data     = '0;
      hold_req     = 1'b0;
      cur_location = 0;
      send_idle    = 33;
      recv_idle    = 64;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_points();
      run_sets(200);

      send_idle = 64;
      recv_idle = 33;
      run_sets(200);

      // back-to-back sets against a receiver that holds off
      settle();
      send_idle = 0;
      recv_idle = 0;
      hold_req  = 1'b1;
      for (int s = 0; s < 8; s++) begin
         send_point(pick_x(), pick_weight(), 1'b0);
         send_point(pick_x(), pick_weight(), 1'b1);
      end

      // small slope keeps p(1-p) near its peak while d^2 is at its largest
      settle();
      write_csr(CSR_LOCATION, 32767);
      write_csr(CSR_SLOPE, 1);
      for (int k = 0; k < SAT_POINTS; k++) send_point(-32768, 65535, k == SAT_POINTS - 1);

      run_sets(100);
      settle();

      $display("Covered %0d design points in %0d matrices, %0d with a saturated d^2 sum.",
               points_seen, matrices_seen, saturated_seen);
      $display("Swept location and slope to both extremes, zero slope, and a long output stall.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
